// ----- rtl/tclbf_pkg.sv -----
// ----------------------------------------------------------------------------
// tclbf_pkg
// Shared widths, codes, reset values and the breathing curve generator for
// the two-channel LED breathe and fade core.
// ----------------------------------------------------------------------------
package tclbf_pkg;

  // parameter defaults
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF       = 16;
  localparam int PWM_MAX_DEF         = 1023;

  // fixed field widths
  localparam int CMD_W        = 2;
  localparam int TICK_W       = 32;
  localparam int STEP_W       = 32;
  localparam int KEEP_W       = 16;
  localparam int GAIN_W       = 17;
  localparam int DONE_W       = 10;
  localparam int LEVEL_W      = 10;
  localparam int FACTOR_FRAC  = 16;
  localparam int OUT_TDATA_W  = 24;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 5;

  // register reset values
  localparam logic [STEP_W-1:0] PHASE_STEP_A_RST        = 32'd478500;
  localparam logic [STEP_W-1:0] PHASE_STEP_B_RST        = 32'd526350;
  localparam logic [KEEP_W-1:0] FADE_OUT_KEEP_RST       = 16'd59578;
  localparam logic [GAIN_W-1:0] FADE_IN_GAIN_RST        = 17'd68157;
  localparam logic [DONE_W-1:0] FADE_OUT_DONE_LEVEL_RST = 10'd1020;
  localparam logic [DONE_W-1:0] FADE_IN_DONE_LEVEL_RST  = 10'd707;

  // command codes carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_FADE_IN  = 2'd1,
    CMD_FADE_OUT = 2'd2
  } cmd_t;

  // register indexes, byte address 4*index
  typedef enum logic [2:0] {
    REG_PHASE_STEP_A        = 3'd0,
    REG_PHASE_STEP_B        = 3'd1,
    REG_FADE_OUT_KEEP       = 3'd2,
    REG_FADE_IN_GAIN        = 3'd3,
    REG_FADE_OUT_DONE_LEVEL = 3'd4,
    REG_FADE_IN_DONE_LEVEL  = 3'd5
  } reg_idx_t;

  // curve generation in Q30, evaluated at elaboration only
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // sine for 0 <= x <= pi/4
  function automatic longint unsigned q30_sin(input longint unsigned x);
    longint unsigned x2;
    longint unsigned h;
    x2 = q30_mul(x, x);
    h  = Q30_ONE - x2 / 72;
    h  = Q30_ONE - q30_mul(x2, h) / 42;
    h  = Q30_ONE - q30_mul(x2, h) / 20;
    h  = Q30_ONE - q30_mul(x2, h) / 6;
    return q30_mul(x, h);
  endfunction

  // cosine for 0 <= x <= pi/4
  function automatic longint unsigned q30_cos(input longint unsigned x);
    longint unsigned x2;
    longint unsigned h;
    x2 = q30_mul(x, x);
    h  = Q30_ONE - x2 / 56;
    h  = Q30_ONE - q30_mul(x2, h) / 30;
    h  = Q30_ONE - q30_mul(x2, h) / 12;
    return Q30_ONE - q30_mul(x2, h) / 2;
  endfunction

  // one entry of pwm_max*|sin(pi*i/n + pi/4)|, rounded
  function automatic logic [31:0] breath_entry(input int unsigned idx,
                                               input int unsigned addr_bits,
                                               input int unsigned pwm_max);
    longint unsigned n;
    longint unsigned k;
    longint unsigned m;
    longint unsigned s;
    n = 64'd1 << addr_bits;
    k = (64'(idx) + (n >> 2)) & (n - 64'd1);
    m = (k <= n - k) ? k : n - k;
    if (m <= (n >> 2)) begin
      s = q30_sin((m * PI_Q30) >> addr_bits);
    end else begin
      s = q30_cos((((n >> 1) - m) * PI_Q30) >> addr_bits);
    end
    return 32'((64'(pwm_max) * s + (Q30_ONE >> 1)) >> 30);
  endfunction

endpackage

// ----- rtl/tclbf_rom.sv -----
// ----------------------------------------------------------------------------
// tclbf_rom
// Breathing curve lookup, two read ports with registered data.
// ----------------------------------------------------------------------------
module tclbf_rom
  import tclbf_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int PWM_MAX         = PWM_MAX_DEF,
  parameter int ROM_W           = $clog2(PWM_MAX + 1)
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [TABLE_ADDR_BITS-1:0] addr_a,
  input  logic [TABLE_ADDR_BITS-1:0] addr_b,
  output logic [ROM_W-1:0]           data_a,
  output logic [ROM_W-1:0]           data_b
);

  localparam int TBL_N = 1 << TABLE_ADDR_BITS;

  logic [ROM_W-1:0] curve [TBL_N];

  // constant curve contents
  for (genvar g = 0; g < TBL_N; g++) begin : g_curve
    assign curve[g] = ROM_W'(breath_entry(g, TABLE_ADDR_BITS, PWM_MAX));
  end

  // registered read, held while the pipeline waits
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= curve[addr_a];
      data_b <= curve[addr_b];
    end
  end

endmodule

// ----- rtl/tclbf_fade.sv -----
// ----------------------------------------------------------------------------
// tclbf_fade
// One channel's fade-out and fade-in step on a fixed-point level.
// ----------------------------------------------------------------------------
module tclbf_fade
  import tclbf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PWM_MAX   = PWM_MAX_DEF,
  parameter int LVL_W     = LEVEL_W + FRAC_BITS
) (
  input  logic [LVL_W-1:0]  level,
  input  logic [KEEP_W-1:0] keep,
  input  logic [GAIN_W-1:0] gain,
  output logic [LVL_W-1:0]  fo_level,
  output logic [LVL_W-1:0]  fi_level
);

  localparam int D_W  = LVL_W + 1;
  localparam int PO_W = LVL_W + KEEP_W;
  localparam int PI_W = D_W + GAIN_W;
  localparam int G_W  = PI_W - FACTOR_FRAC;

  localparam logic [LVL_W-1:0] FULL_FIX  = LVL_W'(PWM_MAX) << FRAC_BITS;
  localparam logic [D_W-1:0]   ABOVE_FIX = D_W'(PWM_MAX + 1) << FRAC_BITS;

  logic [LVL_W-1:0] d_out;
  logic [PO_W-1:0]  prod_out;
  logic [D_W-1:0]   d_in;
  logic [PI_W-1:0]  prod_in;
  logic [G_W-1:0]   grow;

  // fade-out: shrink the distance below full scale
  always_comb begin
    d_out    = (level < FULL_FIX) ? FULL_FIX - level : '0;
    prod_out = PO_W'(d_out) * PO_W'(keep);
    fo_level = FULL_FIX - prod_out[FACTOR_FRAC +: LVL_W];
  end

  // fade-in: grow the distance below full scale plus one, floor at zero
  always_comb begin
    d_in     = (D_W'(level) < ABOVE_FIX) ? ABOVE_FIX - D_W'(level) : '0;
    prod_in  = PI_W'(d_in) * PI_W'(gain);
    grow     = prod_in[FACTOR_FRAC +: G_W];
    fi_level = (grow <= G_W'(FULL_FIX)) ? LVL_W'(G_W'(FULL_FIX) - grow) : '0;
  end

endmodule

// ----- rtl/two_channel_led_breathe_fade_core.sv -----
// ----------------------------------------------------------------------------
// two_channel_led_breathe_fade_core
// Two-channel PWM level generator with breathing curve, fade-in and fade-out.
//
//   channel   direction  handshake        payload
//   s_axis    in         tvalid/tready    tdata now_tick, tuser command
//   m_axis    out        tvalid/tready    tdata level_a, level_b
//   apb       in         psel/penable     six control registers, 4-byte stride
//
// One item per cycle while the output is not stalled; an accepted item is
// registered in the input stage, the curve read stage and the output in turn.
// The update stage holds two fade multiplies per channel, fed by the level
// forwarded from the curve read stage; the curve has a registered read.
// Reset is synchronous; pipeline, levels, fades clear; breathing on; regs reload.
// While a result waits at the output, two more items are still accepted.
// ----------------------------------------------------------------------------
module two_channel_led_breathe_fade_core
  import tclbf_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int PWM_MAX         = PWM_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TICK_W-1:0]      s_axis_tdata,   // [31:0] now_tick
  input  logic [CMD_W-1:0]       s_axis_tuser,   // [1:0] command
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] level_a, [19:10] level_b
  // control registers
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int ROM_W  = $clog2(PWM_MAX + 1);
  localparam int INT_W  = (ROM_W > DONE_W) ? ROM_W : DONE_W;
  localparam int LVL_W  = INT_W + FRAC_BITS;
  localparam int WIDE_W = LVL_W + LEVEL_W;

  localparam logic [LVL_W-1:0] FULL_FIX = LVL_W'(PWM_MAX) << FRAC_BITS;

  // control registers
  logic [STEP_W-1:0] phase_step_a;
  logic [STEP_W-1:0] phase_step_b;
  logic [KEEP_W-1:0] fade_out_keep;
  logic [GAIN_W-1:0] fade_in_gain;
  logic [DONE_W-1:0] fade_out_done_level;
  logic [DONE_W-1:0] fade_in_done_level;
  logic              cfg_write;
  reg_idx_t          cfg_idx;

  // mode state
  logic              breathing_on, breathing_on_next;
  logic              fading_out, fading_out_next;
  logic              fading_in, fading_in_next;
  logic [TICK_W-1:0] tick_base, tick_base_next;
  logic [LVL_W-1:0]  level_a, level_b;

  // input stage
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [TICK_W-1:0] s1_now;

  // curve read stage
  logic              s2_valid;
  logic              s2_has_res, s2_has_res_next;
  logic              s2_from_rom, s2_from_rom_next;
  logic [LVL_W-1:0]  s2_lvl_a, s2_lvl_a_next;
  logic [LVL_W-1:0]  s2_lvl_b, s2_lvl_b_next;
  logic [ROM_W-1:0]  rom_a, rom_b;

  // flow control
  logic out_en;
  logic s2_free;
  logic s1_move;

  // datapath
  logic [LVL_W-1:0]           fin_a, fin_b;
  logic [LVL_W-1:0]           eff_a, eff_b;
  logic [LVL_W-1:0]           fo_a, fo_b, fi_a, fi_b;
  logic [LVL_W-1:0]           lim_out, lim_in;
  logic [TICK_W-1:0]          elapsed;
  logic [STEP_W-1:0]          phase_a, phase_b;
  logic [TABLE_ADDR_BITS-1:0] addr_a, addr_b;
  logic [WIDE_W-1:0]          wide_a, wide_b;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step_a        <= PHASE_STEP_A_RST;
      phase_step_b        <= PHASE_STEP_B_RST;
      fade_out_keep       <= FADE_OUT_KEEP_RST;
      fade_in_gain        <= FADE_IN_GAIN_RST;
      fade_out_done_level <= FADE_OUT_DONE_LEVEL_RST;
      fade_in_done_level  <= FADE_IN_DONE_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_PHASE_STEP_A:        phase_step_a        <= pwdata[STEP_W-1:0];
        REG_PHASE_STEP_B:        phase_step_b        <= pwdata[STEP_W-1:0];
        REG_FADE_OUT_KEEP:       fade_out_keep       <= pwdata[KEEP_W-1:0];
        REG_FADE_IN_GAIN:        fade_in_gain        <= pwdata[GAIN_W-1:0];
        REG_FADE_OUT_DONE_LEVEL: fade_out_done_level <= pwdata[DONE_W-1:0];
        REG_FADE_IN_DONE_LEVEL:  fade_in_done_level  <= pwdata[DONE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_PHASE_STEP_A:        prdata = APB_DATA_W'(phase_step_a);
      REG_PHASE_STEP_B:        prdata = APB_DATA_W'(phase_step_b);
      REG_FADE_OUT_KEEP:       prdata = APB_DATA_W'(fade_out_keep);
      REG_FADE_IN_GAIN:        prdata = APB_DATA_W'(fade_in_gain);
      REG_FADE_OUT_DONE_LEVEL: prdata = APB_DATA_W'(fade_out_done_level);
      REG_FADE_IN_DONE_LEVEL:  prdata = APB_DATA_W'(fade_in_done_level);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- flow control
  assign out_en        = !m_axis_tvalid || m_axis_tready;
  assign s2_free       = !s2_valid || !s2_has_res || out_en;
  assign s1_move       = s1_valid && s2_free;
  assign s_axis_tready = !s1_valid || s2_free;

  // ------------------------------------------------------------ input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_cmd <= s_axis_tuser;
      s1_now <= s_axis_tdata;
    end
  end

  // ------------------------------------------------------- level forwarding
  // levels left by the item in the curve read stage
  assign fin_a = s2_from_rom ? (LVL_W'(rom_a) << FRAC_BITS) : s2_lvl_a;
  assign fin_b = s2_from_rom ? (LVL_W'(rom_b) << FRAC_BITS) : s2_lvl_b;
  assign eff_a = s2_valid ? fin_a : level_a;
  assign eff_b = s2_valid ? fin_b : level_b;

  // fade steps
  tclbf_fade #(
    .FRAC_BITS (FRAC_BITS),
    .PWM_MAX   (PWM_MAX),
    .LVL_W     (LVL_W)
  ) u_fade_a (
    .level    (eff_a),
    .keep     (fade_out_keep),
    .gain     (fade_in_gain),
    .fo_level (fo_a),
    .fi_level (fi_a)
  );

  tclbf_fade #(
    .FRAC_BITS (FRAC_BITS),
    .PWM_MAX   (PWM_MAX),
    .LVL_W     (LVL_W)
  ) u_fade_b (
    .level    (eff_b),
    .keep     (fade_out_keep),
    .gain     (fade_in_gain),
    .fo_level (fo_b),
    .fi_level (fi_b)
  );

  // breathing phase and curve address
  assign elapsed = s1_now - tick_base;
  assign phase_a = phase_step_a * elapsed;
  assign phase_b = phase_step_b * elapsed;
  assign addr_a  = phase_a[STEP_W-1 -: TABLE_ADDR_BITS];
  assign addr_b  = phase_b[STEP_W-1 -: TABLE_ADDR_BITS];

  tclbf_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .PWM_MAX         (PWM_MAX),
    .ROM_W           (ROM_W)
  ) u_rom (
    .clk    (clk),
    .en     (s1_move),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  // ------------------------------------------------------------ mode update
  assign lim_out = LVL_W'(fade_out_done_level) << FRAC_BITS;
  assign lim_in  = LVL_W'(fade_in_done_level) << FRAC_BITS;

  always_comb begin
    breathing_on_next = breathing_on;
    fading_out_next   = fading_out;
    fading_in_next    = fading_in;
    tick_base_next    = tick_base;
    s2_has_res_next   = 1'b0;
    s2_from_rom_next  = 1'b0;
    s2_lvl_a_next     = eff_a;
    s2_lvl_b_next     = eff_b;
    unique case (s1_cmd)
      CMD_FADE_IN: begin
        breathing_on_next = 1'b1;
        fading_in_next    = 1'b1;
      end
      CMD_FADE_OUT: begin
        breathing_on_next = 1'b0;
        fading_out_next   = 1'b1;
      end
      CMD_UPDATE: begin
        s2_has_res_next = 1'b1;
        if (fading_out) begin
          // fade-out has priority; snap to full scale when both arrive
          if (fo_a >= lim_out && fo_b >= lim_out) begin
            fading_out_next = 1'b0;
            s2_lvl_a_next   = FULL_FIX;
            s2_lvl_b_next   = FULL_FIX;
          end else begin
            s2_lvl_a_next = fo_a;
            s2_lvl_b_next = fo_b;
          end
        end else if (fading_in) begin
          // fade-in end snaps to the done level and restarts the phase
          if (fi_a <= lim_in && fi_b <= lim_in) begin
            fading_in_next = 1'b0;
            tick_base_next = s1_now;
            s2_lvl_a_next  = lim_in;
            s2_lvl_b_next  = lim_in;
          end else begin
            s2_lvl_a_next = fi_a;
            s2_lvl_b_next = fi_b;
          end
        end else if (breathing_on) begin
          s2_from_rom_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      breathing_on <= 1'b1;
      fading_out   <= 1'b0;
      fading_in    <= 1'b0;
      tick_base    <= '0;
    end else if (s1_move) begin
      breathing_on <= breathing_on_next;
      fading_out   <= fading_out_next;
      fading_in    <= fading_in_next;
      tick_base    <= tick_base_next;
    end
  end

  // ------------------------------------------------------- curve read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_has_res  <= s2_has_res_next;
      s2_from_rom <= s2_from_rom_next;
      s2_lvl_a    <= s2_lvl_a_next;
      s2_lvl_b    <= s2_lvl_b_next;
    end
  end

  // level state follows the item leaving the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      level_a <= '0;
      level_b <= '0;
    end else if (s2_valid && s2_free) begin
      level_a <= fin_a;
      level_b <= fin_b;
    end
  end

  // ---------------------------------------------------------- output stage
  assign wide_a = WIDE_W'(fin_a);
  assign wide_b = WIDE_W'(fin_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= s2_valid && s2_has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid && s2_has_res) begin
      m_axis_tdata <= OUT_TDATA_W'({wide_b[FRAC_BITS +: LEVEL_W],
                                    wide_a[FRAC_BITS +: LEVEL_W]});
    end
  end

endmodule

// ----- rtl/tclbf_checker.sv -----
// ----------------------------------------------------------------------------
// tclbf_checker
// Port-level checks on the breathe and fade core, bound to the top level.
// ----------------------------------------------------------------------------
module tclbf_checker
  import tclbf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // no result is left over from before reset
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a waiting result holds its value
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // a free output register always frees the input
  a_ready_when_output_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output register free");

  // the input only stalls behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no result waiting");

endmodule

bind two_channel_led_breathe_fade_core tclbf_checker u_tclbf_checker (.*);
